// ===== sv/fnvu_pkg.sv =====
// Shared types, constants and hash helpers for the FNV-1a text-to-id block.
package fnvu_pkg;

    localparam int unsigned SUFFIX_LENGTH = 9;
    localparam int unsigned POS_W         = 4;

    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // UUID version 4 nibble in the upper word, variant 10 in the lower word
    localparam logic [63:0] VER_CLEAR = ~(64'hf0 << 48);
    localparam logic [63:0] VER_SET   = 64'h40 << 48;
    localparam logic [63:0] VAR_CLEAR = ~64'hc0;
    localparam logic [63:0] VAR_SET   = 64'h80;

    typedef enum logic [1:0] {
        ST_TEXT,
        ST_SUFFIX,
        ST_LOAD
    } fnvu_state_t;

    typedef struct packed {
        logic step_text;
        logic save_text;
        logic step_suffix;
        logic load_out;
    } fnvu_cmd_t;

    typedef struct packed {
        logic suffix_last;
    } fnvu_sts_t;

    // Fixed ASCII suffix hashed after the final text byte
    function automatic logic [7:0] suffix_byte(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'h2f;
            4'd1:    b = 8'h68;
            4'd2:    b = 8'h6f;
            4'd3:    b = 8'h75;
            4'd4:    b = 8'h73;
            4'd5:    b = 8'h65;
            4'd6:    b = 8'h67;
            4'd7:    b = 8'h65;
            4'd8:    b = 8'h6e;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Multiply by the FNV prime 2^40 + 2^8 + 0xb3, modulo 2^64, as shifted adds
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

// ===== sv/fnvu_ctrl.sv =====
// Sequencer for the text, suffix and result phases of the id block.
module fnvu_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               final_byte,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  fnvu_pkg::fnvu_sts_t sts,
    output fnvu_pkg::fnvu_cmd_t cmd
);
    import fnvu_pkg::*;

    fnvu_state_t state_reg;
    fnvu_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_TEXT:
            begin
                if (in_valid && final_byte)
                begin
                    state_next = ST_SUFFIX;
                end
            end
            ST_SUFFIX:
            begin
                if (sts.suffix_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_TEXT;
                end
            end
            default:
            begin
                state_next = ST_TEXT;
            end
        endcase
    end

    always_comb
    begin
        in_stall        = 1'b1;
        cmd.step_text   = 1'b0;
        cmd.save_text   = 1'b0;
        cmd.step_suffix = 1'b0;
        cmd.load_out    = 1'b0;
        unique case (state_reg)
            ST_TEXT:
            begin
                in_stall      = 1'b0;
                cmd.step_text = in_valid;
                cmd.save_text = in_valid && final_byte;
            end
            ST_SUFFIX:
            begin
                cmd.step_suffix = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TEXT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/fnvu_dpath.sv =====
// Hash registers, suffix counter and result registers of the id block.
module fnvu_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          text_byte,
    input  fnvu_pkg::fnvu_cmd_t cmd,
    output fnvu_pkg::fnvu_sts_t sts,
    output logic [63:0]         id_upper,
    output logic [63:0]         id_lower
);
    import fnvu_pkg::*;

    logic [63:0]      hash_reg;
    logic [63:0]      hash_next;
    logic [63:0]      saved_reg;
    logic [63:0]      saved_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [63:0]      upper_reg;
    logic [63:0]      lower_reg;
    logic [7:0]       byte_sel;
    logic [63:0]      product;

    assign sts.suffix_last = (pos_reg == POS_W'(SUFFIX_LENGTH - 1));

    assign byte_sel = cmd.step_suffix ? suffix_byte(pos_reg) : text_byte;
    assign product  = fnv_mul(hash_reg ^ {56'd0, byte_sel});

    always_comb
    begin
        hash_next  = hash_reg;
        saved_next = saved_reg;
        pos_next   = pos_reg;
        if (cmd.step_text || cmd.step_suffix)
        begin
            hash_next = product;
        end
        else if (cmd.load_out)
        begin
            hash_next = FNV_BASIS;
        end
        if (cmd.save_text)
        begin
            saved_next = product;
        end
        if (cmd.step_suffix)
        begin
            pos_next = sts.suffix_last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= FNV_BASIS;
            saved_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            saved_reg <= saved_next;
            pos_reg   <= pos_next;
        end
    end

    // Force version and variant as the result is captured
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            upper_reg <= (hash_reg & VER_CLEAR) | VER_SET;
            lower_reg <= (saved_reg & VAR_CLEAR) | VAR_SET;
        end
    end

    assign id_upper = upper_reg;
    assign id_lower = lower_reg;

endmodule

// ===== sv/fnv1a_uuid_from_text_core.sv =====
// Top level of the FNV-1a text-to-id block: controller plus datapath.
//
// Key text enters one byte per item, one item per cycle while in_stall is
// low, and each byte updates a running 64-bit FNV-1a hash (XOR the byte
// in, multiply by the FNV prime as a constant shift-and-add). A byte
// carrying final_byte closes the text: its hash becomes the lower word,
// then the hash runs on over a fixed nine-byte suffix, one suffix byte
// per cycle through the same multiply unit, to give the upper word.
// Version 4 is forced into bits 55..52 of id_upper and the RFC 4122
// variant into bits 7..6 of id_lower, and the running hash returns to
// the offset basis. After a final byte the input stalls through the
// suffix steps and the result load, longer if the previous id is still
// waiting in the output register. The output register frees the input
// side: text for the next id is taken while an id waits to be taken.
module fnv1a_uuid_from_text_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] id_upper,
    output logic [63:0] id_lower
);
    import fnvu_pkg::*;

    fnvu_cmd_t cmd;
    fnvu_sts_t sts;

    // Sequence text, suffix and result load
    fnvu_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_byte (final_byte),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Hold the hash state and the finished id
    fnvu_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (text_byte),
        .cmd       (cmd),
        .sts       (sts),
        .id_upper  (id_upper),
        .id_lower  (id_lower)
    );

`ifndef SYNTHESIS
    // No text byte may be taken while the suffix is being hashed
    a_suffix_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_suffix |-> in_stall)
        else $error("text byte accepted during suffix hashing");

    // The suffix walk stops after its last byte
    a_suffix_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_suffix && sts.suffix_last) |=> !cmd.step_suffix)
        else $error("suffix walk ran past its last byte");

    // A new id appears only from a result load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("output valid without a result load");

    // A result is loaded only once the suffix counter is back at its start
    a_load_after_suffix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.suffix_last && !cmd.step_suffix)
        else $error("result loaded mid-suffix");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the FNV-1a text-to-id core: directed table, then random text.
module testbench;
    import fnvu_pkg::*;

    // FNV prime and the fixed suffix, kept here so that the id predictor
    // stands apart from the multiply network inside the block
    localparam logic [63:0] HASH_PRIME     = 64'd1099511628211;
    localparam logic [71:0] TAG_SUFFIX     = 72'h2f_68_6f_75_73_65_67_65_6e;
    localparam logic [3:0]  VERSION_NIBBLE = 4'b0100;
    localparam logic [1:0]  VARIANT_BITS   = 2'b10;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int IDLE_PERCENT  = 13;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int DIRECTED_ROWS = 17;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } text_id_t;

    // One row of the directed table: a byte, its final mark, and where the
    // text hash is a published FNV-1a value, that value with the variant forced
    typedef struct packed {
        logic [7:0]  text;
        logic        last;
        logic        typed;
        logic [63:0] typed_lower;
    } text_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        final_byte;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] id_upper;
    logic [63:0] id_lower;

    text_id_t    pending_ids[$];
    text_row_t   directed_rows [DIRECTED_ROWS];
    logic [63:0] text_hash;
    int          mismatch_count;
    int          quiet_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_req;

    fnv1a_uuid_from_text_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .id_upper   (id_upper),
        .id_lower   (id_lower)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // One FNV-1a round: fold the byte in, then multiply modulo 2^64
    function automatic logic [63:0] hash_round(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * HASH_PRIME;
    endfunction

    // Advance the text hash by one accepted byte; on a final byte build the
    // id (suffix run, version and variant forced) and restart from the basis
    task automatic predict_id(input logic [7:0] b, input logic last,
                              output bit produced, output text_id_t id);
        logic [63:0] h;
        begin
            text_hash = hash_round(text_hash, b);
            produced  = last;
            id        = '0;
            if (last)
            begin
                id.lower      = text_hash;
                id.lower[7:6] = VARIANT_BITS;
                h = text_hash;
                for (int i = 0; i < SUFFIX_LENGTH; i++)
                    h = hash_round(h, TAG_SUFFIX[71 - 8 * i -: 8]);
                id.upper        = h;
                id.upper[55:52] = VERSION_NIBBLE;
                text_hash = FNV_BASIS;
            end
        end
    endtask

    // Offer one item at the falling edge, hold it until it is taken, then
    // queue whatever id it completes
    task automatic send_item(input logic [7:0] b, input logic last,
                             input logic typed, input logic [63:0] typed_lower);
        bit       produced;
        text_id_t id;
        begin
            @(negedge clk);
            while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid   <= 1'b1;
            text_byte  <= b;
            final_byte <= last;
            do
                @(posedge clk);
            while (in_stall);
            predict_id(b, last, produced, id);
            if (produced)
            begin
                if (typed)
                    id.lower = typed_lower;
                pending_ids.insert(pending_ids.size(), id);
            end
        end
    endtask

    // Send whole random texts until at least n_items bytes have gone in.
    // Most texts are short; now and then a long one stretches the hash.
    task automatic send_texts(input int n_items, input int max_len);
        int          sent;
        int          len;
        logic [7:0]  b;
        begin
            sent = 0;
            while (sent < n_items)
            begin
                if (max_len > 16 && $urandom_range(8) == 0)
                    len = $urandom_range(max_len, 17);
                else
                    len = $urandom_range((max_len < 16) ? max_len : 16, 1);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(3) == 0)
                        b = 8'($urandom_range(8'h7e, 8'h20));
                    else
                        b = 8'($urandom_range(255));
                    send_item(b, k == len - 1, 1'b0, 64'd0);
                end
                sent += len;
            end
        end
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Check each id taken against the oldest one queued, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_ids.size() == 0)
                begin
                    $display("%0t: unexpected id, upper %h lower %h", $time, id_upper, id_lower);
                    mismatch_count++;
                end
                else
                begin
                    if (id_upper !== pending_ids[0].upper)
                    begin
                        $display("%0t: id_upper expected %h got %h",
                                 $time, pending_ids[0].upper, id_upper);
                        mismatch_count++;
                    end
                    if (id_lower !== pending_ids[0].lower)
                    begin
                        $display("%0t: id_lower expected %h got %h",
                                 $time, pending_ids[0].lower, id_lower);
                        mismatch_count++;
                    end
                    void'(pending_ids.pop_front());
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("[fnv1a_uuid_from_text_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        text_byte      = 8'd0;
        final_byte     = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        hold_req       = 1'b0;
        text_hash      = FNV_BASIS;

        // Directed table. "a" and "foobar" carry their published FNV-1a
        // hashes (variant already forced) so the lower word is checked
        // against a known value; the rest go through the predictor.
        directed_rows = '{
            '{8'h61, 1'b1, 1'b1, 64'haf63dc4c8601ec8c},
            '{8'h66, 1'b0, 1'b0, 64'd0},
            '{8'h6f, 1'b0, 1'b0, 64'd0},
            '{8'h6f, 1'b0, 1'b0, 64'd0},
            '{8'h62, 1'b0, 1'b0, 64'd0},
            '{8'h61, 1'b0, 1'b0, 64'd0},
            '{8'h72, 1'b1, 1'b1, 64'h85944171f73967a8},
            '{8'h00, 1'b1, 1'b0, 64'd0},
            '{8'hff, 1'b1, 1'b0, 64'd0},
            '{8'h00, 1'b0, 1'b0, 64'd0},
            '{8'hff, 1'b0, 1'b0, 64'd0},
            '{8'h55, 1'b0, 1'b0, 64'd0},
            '{8'haa, 1'b1, 1'b0, 64'd0},
            '{8'h80, 1'b1, 1'b0, 64'd0},
            '{8'h01, 1'b1, 1'b0, 64'd0},
            '{8'h7f, 1'b0, 1'b0, 64'd0},
            '{8'hfe, 1'b1, 1'b0, 64'd0}
        };

        // Hold reset at start, then release it at a falling edge, away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(directed_rows[r].text, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].typed_lower);

        // Random texts with idling on both sides
        send_texts(450, 40);

        // Long stretch with no idling at all
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_texts(250, 40);
        rx_idle_on = 1'b1;

        // Back-pressure: hold the receiver off while short texts keep
        // arriving, so the output register fills and the input stalls
        hold_req = 1'b1;
        send_texts(40, 3);
        tx_idle_on = 1'b1;

        send_texts(RANDOM_ITEMS - 740, 40);

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain every queued id, then let the block idle before the final check
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_ids.size() == 0)
            $display("[fnv1a_uuid_from_text_core] OK");
        else
            $display("[fnv1a_uuid_from_text_core] ERROR");
        $finish;
    end

endmodule
